@@ hdl/wcts_pkg.sv @@
// ----------------------------------------------------------------------------
// wcts_pkg
// Shared types and constants of the wall column texture shader.
// ----------------------------------------------------------------------------
package wcts_pkg;

  // Register indexes, as seen at paddr[4:2]
  localparam logic [2:0] REG_PROJ_DIST  = 3'd0;
  localparam logic [2:0] REG_BOB_OFFSET = 3'd1;
  localparam logic [2:0] REG_LIGHT_GRAD = 3'd2;
  localparam logic [2:0] REG_TEX_WIDTH  = 3'd3;
  localparam logic [2:0] REG_TEX_STRIDE = 3'd4;

  localparam logic [19:0] PROJ_DIST_RST  = 20'd65536;
  localparam logic [15:0] BOB_OFFSET_RST = 16'd0;
  localparam logic [15:0] LIGHT_GRAD_RST = 16'd786;
  localparam logic [8:0]  TEX_WIDTH_RST  = 9'd128;
  localparam logic [8:0]  TEX_STRIDE_RST = 9'd128;

  // Shared divider widths
  localparam int unsigned DIV_NW = 53;  // dividend / quotient
  localparam int unsigned DIV_DW = 37;  // divisor / remainder

  localparam int unsigned QDEPTH = 4;   // front to back queue

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_DRAW  = 1'b1
  } op_e;

  typedef struct packed {
    logic        mode;
    logic [13:0] tex_addr;
    logic [23:0] texel_data;
    logic [20:0] wall_dist;
    logic [15:0] wall_offset;
    logic [9:0]  column_x;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [5:0]  out_row;
    logic [23:0] pixel_color;
    logic [6:0]  column_end;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [19:0] proj_dist;
    logic [15:0] bob_offset;
    logic [15:0] light_grad;
    logic [8:0]  tex_width;
    logic [8:0]  tex_row_stride;
  } cfg_t;

  // Classified item as held in the queue
  typedef struct packed {
    op_e         op;
    logic [13:0] addr;
    logic [23:0] texel;
    logic [20:0] wdist;  // zero already mapped to one LSB
    logic [15:0] offset;
    logic [9:0]  column;
  } q_entry_t;

  typedef struct packed {
    logic              start;
    logic [5:0]        steps;
    logic [DIV_NW-1:0] dividend;  // left aligned
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_stat_t;

endpackage

@@ hdl/wcts_front.sv @@
// ----------------------------------------------------------------------------
// wcts_front
// Accepts input beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module wcts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wcts_pkg::in_beat_t in_beat_i,
  output logic               q_valid_o,
  output wcts_pkg::q_entry_t q_entry_o,
  input  logic               q_pop_i
);

  localparam int unsigned PW = $clog2(wcts_pkg::QDEPTH);

  wcts_pkg::q_entry_t        mem_q [wcts_pkg::QDEPTH];
  logic [PW-1:0]             wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW:0]               cnt_q, cnt_d;
  logic                      push, pop;
  wcts_pkg::q_entry_t        ent;

  assign in_stall_o = (cnt_q == (PW+1)'(wcts_pkg::QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    ent.op     = in_beat_i.mode ? wcts_pkg::OP_DRAW : wcts_pkg::OP_WRITE;
    ent.addr   = in_beat_i.tex_addr;
    ent.texel  = in_beat_i.texel_data;
    ent.wdist  = (in_beat_i.wall_dist == '0) ? 21'd1 : in_beat_i.wall_dist;
    ent.offset = in_beat_i.wall_offset;
    ent.column = in_beat_i.column_x;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ent;
    end
  end

endmodule

@@ hdl/wcts_div.sv @@
// ----------------------------------------------------------------------------
// wcts_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wcts_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wcts_pkg::div_req_t  req_i,
  output wcts_pkg::div_stat_t stat_o
);

  localparam int unsigned NW = wcts_pkg::DIV_NW;
  localparam int unsigned DW = wcts_pkg::DIV_DW;

  logic [NW-1:0] q_q, q_d;
  logic [DW-1:0] rem_q, rem_d, div_q, div_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, q_q[NW-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    q_d    = q_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      q_d    = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DW'(trial - {1'b0, div_q}) : DW'(trial);
      q_d   = {q_q[NW-2:0], fits};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.quot = q_q;
  assign stat_o.rem  = rem_q;

endmodule

@@ hdl/wcts_back.sv @@
// ----------------------------------------------------------------------------
// wcts_back
// Executes queued items: texel writes, column setup and per-row shading.
// ----------------------------------------------------------------------------
module wcts_back #(
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned TEX_DEPTH     = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wcts_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  wcts_pkg::q_entry_t  q_entry_i,
  output logic                q_pop_o,
  output wcts_pkg::div_req_t  div_req_o,
  input  wcts_pkg::div_stat_t div_stat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wcts_pkg::out_beat_t out_beat_o
);

  localparam int unsigned AW = $clog2(TEX_DEPTH);
  localparam int unsigned RW = $clog2(SCREEN_HEIGHT);
  localparam logic signed [54:0] MID = 55'(SCREEN_HEIGHT / 2) <<< 23;
  localparam logic signed [32:0] SH_S = 33'(SCREEN_HEIGHT);
  localparam logic signed [31:0] SH_S32 = 32'(SCREEN_HEIGHT);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_H8    = 9'b000000010,
    S_M     = 9'b000000100,
    S_TC    = 9'b000001000,
    S_PREP  = 9'b000010000,
    S_QS    = 9'b000100000,
    S_Q0    = 9'b001000000,
    S_ADDR  = 9'b010000000,
    S_SHADE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [23:0] tex_mem [TEX_DEPTH];
  logic [23:0] rdata_q;
  logic        rd_en;
  logic [AW-1:0] raddr;

  // per-draw working registers
  logic [20:0]        d_q;
  logic [19:0]        p_q;
  logic [15:0]        g_q;
  logic [8:0]         tw_q, stride_q;
  logic signed [15:0] bob_q;
  logic [15:0]        woff_q;
  logic [9:0]         col_q;
  logic [34:0]        h8_q;
  logic [16:0]        m_q;
  logic signed [54:0] top_q, bot_q;
  logic [8:0]         tcol_q;
  logic signed [31:0] cs_q;
  logic [6:0]         colend_q;
  logic               empty_q;
  logic [RW-1:0]      row_q;
  logic [AW-1:0]      qstep_q, trow_q;
  logic [19:0]        rstep_q, trem_q;

  logic                   out_valid_q;
  wcts_pkg::out_beat_t    out_q;
  logic                   out_free;

  // combinational helpers
  logic signed [16:0] k_top, k_bot;
  logic signed [35:0] h8_s;
  logic signed [31:0] cs_c;
  logic signed [32:0] ce_c;
  logic [6:0]         colend_c;
  logic signed [32:0] first_c;
  logic [31:0]        dy0;
  logic [52:0]        dyd;
  logic [36:0]        dg;
  logic [AW+8:0]      addr_w;
  logic [16:0]        qclamp_dummy;
  logic [24:0]        sr, sg, sb;
  logic [20:0]        trem_sum;
  logic               last_row;

  wcts_pkg::div_req_t req;

  assign out_free = !out_valid_q || !out_stall_i;
  assign k_top = 17'sd16384 + {bob_q[15], bob_q};
  assign k_bot = 17'sd16384 - {bob_q[15], bob_q};
  assign h8_s  = $signed({1'b0, h8_q});
  assign dg    = 37'(d_q) * 37'(g_q);
  assign dy0   = 32'($signed({{(32-RW){1'b0}}, row_q}) - cs_q);
  assign dyd   = 53'(dy0) * 53'(d_q);

  // truncating shift of the signed top edge
  always_comb begin
    if (top_q >= 0) begin
      cs_c = 32'(top_q >>> 23);
    end else begin
      cs_c = -32'((-top_q) >>> 23);
    end
    ce_c = (bot_q > 0) ? 33'((bot_q + 55'sd8388607) >>> 23) : 33'sd0;
    colend_c = (ce_c >= SH_S) ? 7'(SCREEN_HEIGHT) : 7'(ce_c);
    first_c  = (cs_c < 0) ? 33'sd0 : 33'(cs_c);
  end

  assign qclamp_dummy = (div_stat_i.quot > 53'd65536) ? 17'd65536
                                                       : 17'(div_stat_i.quot);
  assign addr_w   = (AW+9)'(trow_q) * (AW+9)'(stride_q) + (AW+9)'(tcol_q);
  assign raddr    = addr_w[AW-1:0];
  assign sr       = 25'(rdata_q[7:0])   * 25'(m_q);
  assign sg       = 25'(rdata_q[15:8])  * 25'(m_q);
  assign sb       = 25'(rdata_q[23:16]) * 25'(m_q);
  assign trem_sum = 21'(trem_q) + 21'(rstep_q);
  assign last_row = (7'(row_q) + 7'd1 == colend_q);

  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    req         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_entry_i.op == wcts_pkg::OP_DRAW) begin
            req.start    = 1'b1;
            req.steps    = 6'd35;
            req.dividend = {(cfg_i.proj_dist == '0) ? 20'd1 : cfg_i.proj_dist, 33'd0};
            req.divisor  = 37'(q_entry_i.wdist);
            state_d      = S_H8;
          end
        end
      end
      S_H8: begin
        if (div_stat_i.done) begin
          req.start    = 1'b1;
          req.steps    = 6'd41;
          req.dividend = {1'b1, 52'd0};
          req.divisor  = dg;
          state_d      = S_M;
        end
      end
      S_M: begin
        if (div_stat_i.done) begin
          req.start    = 1'b1;
          req.steps    = 6'd16;
          req.dividend = {woff_q, 37'd0};
          req.divisor  = 37'(tw_q);
          state_d      = S_TC;
        end
      end
      S_TC: begin
        if (div_stat_i.done) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (empty_q) begin
          state_d = S_IDLE;
        end else begin
          req.start    = 1'b1;
          req.steps    = 6'd21;
          req.dividend = {d_q, 32'd0};
          req.divisor  = 37'(p_q);
          state_d      = S_QS;
        end
      end
      S_QS: begin
        if (div_stat_i.done) begin
          req.start    = 1'b1;
          req.steps    = 6'd53;
          req.dividend = dyd;
          req.divisor  = 37'(p_q);
          state_d      = S_Q0;
        end
      end
      S_Q0: begin
        if (div_stat_i.done) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        rd_en   = 1'b1;
        state_d = S_SHADE;
      end
      S_SHADE: begin
        if (out_free) begin
          state_d = last_row ? S_IDLE : S_ADDR;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign div_req_o = req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      row_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SHADE && out_free) begin
        out_valid_q <= 1'b1;
        row_q       <= row_q + RW'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_TC && div_stat_i.done) begin
        row_q <= RW'(first_c);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) begin
      d_q      <= q_entry_i.wdist;
      p_q      <= (cfg_i.proj_dist == '0) ? 20'd1 : cfg_i.proj_dist;
      g_q      <= (cfg_i.light_grad == '0) ? 16'd1 : cfg_i.light_grad;
      tw_q     <= (cfg_i.tex_width == '0) ? 9'd1 : cfg_i.tex_width;
      stride_q <= cfg_i.tex_row_stride;
      bob_q    <= $signed(cfg_i.bob_offset);
      woff_q   <= q_entry_i.offset;
      col_q    <= q_entry_i.column;
    end
    if (state_q == S_H8 && div_stat_i.done) begin
      h8_q <= 35'(div_stat_i.quot);
    end
    if (state_q == S_M && div_stat_i.done) begin
      m_q   <= qclamp_dummy;
      // products reach 51 bits, so widen before multiplying
      top_q <= MID - (55'(h8_s) * 55'(k_top));
      bot_q <= MID + (55'(h8_s) * 55'(k_bot));
    end
    if (state_q == S_TC && div_stat_i.done) begin
      tcol_q   <= 9'(div_stat_i.rem);
      cs_q     <= cs_c;
      colend_q <= colend_c;
      empty_q  <= (cs_c >= SH_S32) || (first_c >= 33'(colend_c));
    end
    if (state_q == S_QS && div_stat_i.done) begin
      qstep_q <= AW'(div_stat_i.quot);
      rstep_q <= 20'(div_stat_i.rem);
    end
    if (state_q == S_Q0 && div_stat_i.done) begin
      trow_q <= AW'(div_stat_i.quot);
      trem_q <= 20'(div_stat_i.rem);
    end
    if (state_q == S_SHADE && out_free) begin
      out_q.out_column  <= col_q;
      out_q.out_row     <= 6'(row_q);
      out_q.pixel_color <= {sr[23:16], sg[23:16], sb[23:16]};
      out_q.column_end  <= colend_q;
      out_q.last        <= last_row;
      // step the texture row by D/P, carrying the remainder
      if (trem_sum >= 21'(p_q)) begin
        trem_q <= 20'(trem_sum - 21'(p_q));
        trow_q <= trow_q + qstep_q + AW'(1);
      end else begin
        trem_q <= 20'(trem_sum);
        trow_q <= trow_q + qstep_q;
      end
    end
  end

  // texture store
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i && q_entry_i.op == wcts_pkg::OP_WRITE) begin
      tex_mem[AW'(q_entry_i.addr)] <= q_entry_i.texel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= tex_mem[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.last |-> (7'(out_beat_o.out_row) + 7'd1 == out_beat_o.column_end))
    else $error("last beat not at column end");

  a_row_in_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (7'(out_beat_o.out_row) < out_beat_o.column_end))
    else $error("row beyond column end");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |-> !div_stat_i.busy)
    else $error("divider started while busy");

endmodule

@@ hdl/wall_column_texture_shader_unit.sv @@
// ----------------------------------------------------------------------------
// wall_column_texture_shader_unit
// Texture store and textured, distance-shaded wall column renderer.
// ----------------------------------------------------------------------------
// Input beats with mode 0 store one texel; they leave the queue in the same
// cycle as the texel is written. A draw beat goes through a setup run on one
// shared bit-serial divider: column height, shade factor, texture column,
// then, when any row is on screen, the row step D/P and the first texture
// row. Then each on-screen row goes through a texture read and a shade step,
// the shade step waiting while the output is stalled. A four-entry queue
// between the front and back ends lets new beats be taken while a column is
// still being drawn, and the output register holds a finished pixel while the
// back end works on the next one. No reset pass is needed: the texture store
// starts undefined; only written entries may be read, which the user must
// ensure, as the block itself does not enforce it.
// Registers sit on the APB port at byte addresses 0 (proj_dist),
// 4 (bob_offset), 8 (light_grad), 12 (tex_width), 16 (tex_row_stride).
module wall_column_texture_shader_unit #(
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned TEX_DEPTH     = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wcts_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wcts_pkg::out_beat_t out_beat_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  wcts_pkg::cfg_t      cfg_q;
  logic                wr_en;
  logic [2:0]          reg_idx;

  logic                q_valid, q_pop;
  wcts_pkg::q_entry_t  q_entry;
  wcts_pkg::div_req_t  div_req;
  wcts_pkg::div_stat_t div_stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.proj_dist      <= wcts_pkg::PROJ_DIST_RST;
      cfg_q.bob_offset     <= wcts_pkg::BOB_OFFSET_RST;
      cfg_q.light_grad     <= wcts_pkg::LIGHT_GRAD_RST;
      cfg_q.tex_width      <= wcts_pkg::TEX_WIDTH_RST;
      cfg_q.tex_row_stride <= wcts_pkg::TEX_STRIDE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        wcts_pkg::REG_PROJ_DIST:  cfg_q.proj_dist      <= pwdata[19:0];
        wcts_pkg::REG_BOB_OFFSET: cfg_q.bob_offset     <= pwdata[15:0];
        wcts_pkg::REG_LIGHT_GRAD: cfg_q.light_grad     <= pwdata[15:0];
        wcts_pkg::REG_TEX_WIDTH:  cfg_q.tex_width      <= pwdata[8:0];
        wcts_pkg::REG_TEX_STRIDE: cfg_q.tex_row_stride <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      wcts_pkg::REG_PROJ_DIST:  prdata = 32'(cfg_q.proj_dist);
      wcts_pkg::REG_BOB_OFFSET: prdata = 32'(cfg_q.bob_offset);
      wcts_pkg::REG_LIGHT_GRAD: prdata = 32'(cfg_q.light_grad);
      wcts_pkg::REG_TEX_WIDTH:  prdata = 32'(cfg_q.tex_width);
      wcts_pkg::REG_TEX_STRIDE: prdata = 32'(cfg_q.tex_row_stride);
      default:                  prdata = '0;
    endcase
  end

  // Front end: takes beats, classifies, queues
  wcts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  // Shared serial divider for the column setup
  wcts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat)
  );

  // Back end: texture store, setup sequencer and row shader
  wcts_back #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEX_DEPTH     (TEX_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_stat_i  (div_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

@@ tb/sv/wall_column_texture_shader_unit_tb.sv @@
// ----------------------------------------------------------------------------
// wall_column_texture_shader_unit_tb
// Self-checking bench: texel loads and wall column draws against a local
// column renderer model, over several register settings and idling phases.
// ----------------------------------------------------------------------------
module wall_column_texture_shader_unit_tb;

  localparam int unsigned SCREEN_H  = 64;
  localparam int unsigned TEX_WORDS = 16384;
  localparam int unsigned TEX_FILL  = 288;   // texels loaded at the start
  localparam longint      CYCLE_CAP = 2000000;
  localparam int          SETTLE    = 1000;  // longer than a full queue of columns

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  wcts_pkg::in_beat_t  in_beat_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  wcts_pkg::out_beat_t out_beat_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_taken = 1'b0;

  wall_column_texture_shader_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state
  logic [23:0] tex_store [TEX_WORDS];
  bit          tex_known [TEX_WORDS];
  logic [19:0] m_proj;
  logic [15:0] m_bob;
  logic [15:0] m_grad;
  logic [8:0]  m_width;
  logic [8:0]  m_stride;

  wcts_pkg::in_beat_t  beat_q [$];
  wcts_pkg::out_beat_t pixel_q [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int error_count = 0;
  int pixel_count = 0;
  int draw_count  = 0;
  longint cycle_count = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  // Renders one draw into the expected pixel queue.
  task automatic render_column(input wcts_pkg::in_beat_t b);
    longint d, p, g, tw, h8, top, bot, cs, m, tcol, dy, trow, addr, r;
    longint first, lastr;
    int bob;
    logic [23:0] tx;
    wcts_pkg::out_beat_t o;
    d = b.wall_dist;  if (d == 0) d = 1;
    p = m_proj;       if (p == 0) p = 1;
    g = m_grad;       if (g == 0) g = 1;
    tw = m_width;     if (tw == 0) tw = 1;
    bob = $signed(m_bob);
    h8 = (p << 15) / d;
    top = 32 * (64'sd1 << 23) - h8 * (16384 + bob);
    bot = 32 * (64'sd1 << 23) + h8 * (16384 - bob);
    cs = (top >= 0) ? (top >>> 23) : -((-top) >>> 23);
    m = (64'sd1 <<< 40) / (d * g);
    if (m > 65536) m = 65536;
    tcol = b.wall_offset % tw;
    first = -1; lastr = -1;
    for (r = 0; r < SCREEN_H; r++)
      if (r >= cs && r * (64'sd1 << 23) < bot) begin
        if (first < 0) first = r;
        lastr = r;
      end
    if (first < 0) return;
    draw_count++;
    for (r = first; r <= lastr; r++) begin
      dy = r - cs;
      trow = (dy * d) / p;
      addr = (trow * m_stride + tcol) % TEX_WORDS;
      tx = tex_store[addr];
      o.out_column  = b.column_x;
      o.out_row     = r[5:0];
      o.pixel_color = {8'((tx[7:0] * m) >> 16), 8'((tx[15:8] * m) >> 16),
                       8'((tx[23:16] * m) >> 16)};
      o.column_end  = 7'(lastr + 1);
      o.last        = (r == lastr);
      pixel_q.push_back(o);
    end
  endtask

  // Would a draw under the current settings touch only written texels?
  function automatic bit column_safe(input wcts_pkg::in_beat_t b);
    longint d, p, tw, h8, top, bot, cs, tcol, trow, addr, r;
    d = b.wall_dist;  if (d == 0) d = 1;
    p = m_proj;       if (p == 0) p = 1;
    tw = m_width;     if (tw == 0) tw = 1;
    h8 = (p << 15) / d;
    top = 32 * (64'sd1 << 23) - h8 * (16384 + $signed(m_bob));
    bot = 32 * (64'sd1 << 23) + h8 * (16384 - $signed(m_bob));
    cs = (top >= 0) ? (top >>> 23) : -((-top) >>> 23);
    tcol = b.wall_offset % tw;
    for (r = 0; r < SCREEN_H; r++)
      if (r >= cs && r * (64'sd1 << 23) < bot) begin
        trow = ((r - cs) * d) / p;
        addr = (trow * m_stride + tcol) % TEX_WORDS;
        if (!tex_known[addr]) return 0;
      end
    return 1;
  endfunction

  // Driver: presents queued beats, model updated once a beat was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        if (in_beat_i.mode == wcts_pkg::OP_WRITE) begin
          tex_store[in_beat_i.tex_addr] <= in_beat_i.texel_data;
        end else begin
          render_column(in_beat_i);
        end
        void'(beat_q.pop_front());
      end
      if (in_valid_i && !in_taken) begin
        // held beat stays put
      end else if (beat_q.size() > 0 &&
                   $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        in_beat_i  <= beat_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: input acceptance, and pixel beats against the oldest expectation.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    in_taken    <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel col %0d row %0d",
                        out_beat_o.out_column, out_beat_o.out_row));
      end else begin
        wcts_pkg::out_beat_t e;
        e = pixel_q.pop_front();
        pixel_count++;
        if (out_beat_o.out_column !== e.out_column)
          report_mismatch($sformatf("column %0d want %0d",
                          out_beat_o.out_column, e.out_column));
        if (out_beat_o.out_row !== e.out_row)
          report_mismatch($sformatf("row %0d want %0d",
                          out_beat_o.out_row, e.out_row));
        if (out_beat_o.pixel_color !== e.pixel_color)
          report_mismatch($sformatf("colour %h want %h row %0d",
                          out_beat_o.pixel_color, e.pixel_color, e.out_row));
        if (out_beat_o.column_end !== e.column_end)
          report_mismatch($sformatf("column_end %0d want %0d",
                          out_beat_o.column_end, e.column_end));
        if (out_beat_o.last !== e.last)
          report_mismatch($sformatf("last %0b want %0b row %0d",
                          out_beat_o.last, e.last, e.out_row));
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout with %0d pixels outstanding", pixel_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // APB write: setup then access, at falling edges.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      wcts_pkg::REG_PROJ_DIST:  m_proj   = val[19:0];
      wcts_pkg::REG_BOB_OFFSET: m_bob    = val[15:0];
      wcts_pkg::REG_LIGHT_GRAD: m_grad   = val[15:0];
      wcts_pkg::REG_TEX_WIDTH:  m_width  = val[8:0];
      wcts_pkg::REG_TEX_STRIDE: m_stride = val[8:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [19:0] pd, input logic [15:0] bob,
                          input logic [15:0] gr, input logic [8:0] tw,
                          input logic [8:0] ts);
    reg_write(wcts_pkg::REG_PROJ_DIST, 32'(pd));
    reg_write(wcts_pkg::REG_BOB_OFFSET, 32'(bob));
    reg_write(wcts_pkg::REG_LIGHT_GRAD, 32'(gr));
    reg_write(wcts_pkg::REG_TEX_WIDTH, 32'(tw));
    reg_write(wcts_pkg::REG_TEX_STRIDE, 32'(ts));
  endtask

  // Waits until all beats are taken and pixels seen, then lets trailing
  // off-screen draws finish before registers change.
  task automatic drain;
    while (beat_q.size() > 0 || in_valid_i || pixel_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic wcts_pkg::in_beat_t texel_beat(input int a,
                                                    input logic [23:0] c);
    wcts_pkg::in_beat_t b;
    b = '0;
    b.mode = wcts_pkg::OP_WRITE;
    b.tex_addr = a[13:0];
    b.texel_data = c;
    b.wall_dist = 21'($urandom);
    return b;
  endfunction

  function automatic wcts_pkg::in_beat_t draw_beat(input logic [20:0] d,
                                                   input logic [15:0] off,
                                                   input logic [9:0] col);
    wcts_pkg::in_beat_t b;
    b = '0;
    b.mode = wcts_pkg::OP_DRAW;
    b.wall_dist = d;
    b.wall_offset = off;
    b.column_x = col;
    b.tex_addr = 14'($urandom);
    b.texel_data = 24'($urandom);
    return b;
  endfunction

  // Queues a draw only when every texel it reads has been loaded.
  task automatic push_draw(input logic [20:0] d, input logic [15:0] off,
                           input logic [9:0] col);
    wcts_pkg::in_beat_t b;
    b = draw_beat(d, off, col);
    if (column_safe(b)) beat_q.push_back(b);
  endtask

  // Random draws; a draw reaching unloaded texels is redrawn a few times.
  task automatic random_draws(input int n);
    logic [20:0] d;
    wcts_pkg::in_beat_t b;
    int tries;
    for (int i = 0; i < n; i++) begin
      tries = 0;
      do begin
        case ($urandom_range(3))
          0:       d = 21'($urandom_range(1, 255));
          1:       d = 21'($urandom_range(256, 4095));
          2:       d = 21'($urandom);
          default: d = 21'($urandom_range(0, 65535));
        endcase
        b = draw_beat(d, 16'($urandom), 10'($urandom));
        tries++;
      end while (!column_safe(b) && tries < 16);
      if (column_safe(b)) beat_q.push_back(b);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int n);
    sender_idle_pct = idle;
    recv_stall_pct  = stall;
    random_draws(n);
    drain();
  endtask

  initial begin
    m_proj  = wcts_pkg::PROJ_DIST_RST;
    m_bob   = wcts_pkg::BOB_OFFSET_RST;
    m_grad  = wcts_pkg::LIGHT_GRAD_RST;
    m_width = wcts_pkg::TEX_WIDTH_RST;
    m_stride = wcts_pkg::TEX_STRIDE_RST;
    for (int i = 0; i < TEX_WORDS; i++) begin
      tex_store[i] = '0;
      tex_known[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Load the low part of the store; draws keep to it through small
    // strides. Colours are random, with all ones and all zeros as the first two.
    begin
      logic [23:0] c;
      for (int i = 0; i < TEX_FILL; i++) begin
        tex_known[i] = 1'b1;
        c = (i == 0) ? 24'hffffff : (i == 1) ? 24'h000000 : 24'($urandom);
        beat_q.push_back(texel_beat(i, c));
      end
    end
    drain();

    // Directed draws: nearest, farthest, typical, offset extremes and
    // column extremes.
    set_regs(20'd65536, 16'd0, 16'd786, 9'd128, 9'd1);
    push_draw(21'd0, 16'd0, 10'd0);
    push_draw(21'd1, 16'hffff, 10'd1023);
    push_draw(21'h1fffff, 16'd127, 10'd512);
    push_draw(21'd256, 16'd128, 10'd3);
    push_draw(21'd100000, 16'd5, 10'd7);
    push_draw(21'd2000, 16'd300, 10'd9);
    drain();

    // Extremes: zero projection, gradient and width; largest bob either way.
    set_regs(20'd0, 16'h8000, 16'd0, 9'd0, 9'd1);
    push_draw(21'd0, 16'hffff, 10'd11);
    push_draw(21'd300, 16'd42, 10'd12);
    drain();
    set_regs(20'hfffff, 16'h7fff, 16'hffff, 9'd256, 9'd1);
    push_draw(21'd0, 16'h0100, 10'd13);
    push_draw(21'h1fffff, 16'd255, 10'd14);
    push_draw(21'd512, 16'd1000, 10'd15);
    drain();
    set_regs(20'd256, 16'hc000, 16'd1, 9'd1, 9'd2);
    push_draw(21'd256, 16'd77, 10'd16);
    push_draw(21'd1, 16'd78, 10'd17);
    drain();

    // Random phases over several settings and idling patterns.
    set_regs(20'd65536, 16'd0, 16'd786, 9'd64, 9'd1);
    run_phase(0, 0, 34);
    set_regs(20'($urandom_range(256, 200000)), 16'($urandom), 16'($urandom),
             9'($urandom_range(1, 96)), 9'd1);
    run_phase(48, 0, 34);
    set_regs(20'd20000, 16'h1000, 16'd300, 9'd32, 9'd2);
    run_phase(0, 48, 34);
    set_regs(20'($urandom), 16'($urandom), 16'($urandom),
             9'($urandom_range(0, 64)), 9'd1);
    run_phase(14, 14, 34);
    set_regs(20'd65536, 16'hf000, 16'd786, 9'd100, 9'd1);
    run_phase(0, 0, 34);

    $display("covered %0d column draws giving %0d pixels", draw_count, pixel_count);
    $display("across directed extremes and random register settings");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/wcts_pkg.sv
hdl/wcts_front.sv
hdl/wcts_div.sv
hdl/wcts_back.sv
hdl/wall_column_texture_shader_unit.sv
tb/sv/wall_column_texture_shader_unit_tb.sv
